// ----- rtl/bec_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bec_pkg
// Widths and fixed-point constants of the envelope compressor and clipper.
// ----------------------------------------------------------------------------
package bec_pkg;

    localparam int SAMPLE_W = 24;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 25;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAKEUP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RATE      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WET       = 3'd3;

    localparam logic [24:0] ONE_PHASE = 25'd16777216;
    localparam logic [27:0] ACC_MAX   = 28'hFFFFFFF;
    localparam logic [55:0] RED_LIM   = 56'd549755813888;
    localparam logic [16:0] WET_ONE   = 17'd65536;

    localparam logic signed [27:0] CLAMP4      = 28'sd33554432;
    localparam logic signed [27:0] CLIP_THRESH = 28'sd8011058;
    localparam logic signed [26:0] CLIP_OFS_A  = 27'sd5920854;
    localparam logic signed [26:0] CLIP_OFS_C  = 27'sd2090204;
    localparam logic signed [25:0] CLIP_MUL_B  = 26'sd4377424;
    localparam logic signed [25:0] CLIP_MUL_D  = 26'sd12399790;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

endpackage
`default_nettype wire

// ----- rtl/bezier_envelope_compressor_clipper.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bezier_envelope_compressor_clipper
// Feedforward compressor with Bezier-smoothed envelope and a soft clipper.
// ----------------------------------------------------------------------------
// One sample runs through the sequencer states M0 to M17 and C0 to C7
// from the input transfer to the result being offered, and a new sample is
// taken only in idle: every product (envelope, Bezier blend, gain, makeup,
// mix and clipper) runs through one shared 30 x 26 bit signed multiplier
// under a small sequencer, one product per cycle. The input is not ready
// while a sample is in work; a finished result waits in the output register
// and the next sample may be taken meanwhile. Each result is taken from
// r_last, the clipper value held over from the sample before.
module bezier_envelope_compressor_clipper (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  wire  [bec_pkg::SAMPLE_W-1:0]  i_s_axis_tdata,   // [23:0] sample_in
    output logic                          o_m_axis_tvalid,
    input  wire                           i_m_axis_tready,
    output logic [bec_pkg::SAMPLE_W-1:0]  o_m_axis_tdata,   // [23:0] sample_out
    input  wire                           i_cfg_we,
    input  wire  [bec_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire  [bec_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import bec_pkg::*;

    localparam logic [4:0] ST_IDLE = 5'd0,  ST_M0  = 5'd1,  ST_M1  = 5'd2,  ST_M2  = 5'd3,
                           ST_M3   = 5'd4,  ST_M4  = 5'd5,  ST_M5  = 5'd6,  ST_M6  = 5'd7,
                           ST_M7   = 5'd8,  ST_M8  = 5'd9,  ST_M9  = 5'd10, ST_M10 = 5'd11,
                           ST_M11  = 5'd12, ST_M12 = 5'd13, ST_M13 = 5'd14, ST_M14 = 5'd15,
                           ST_M15  = 5'd16, ST_M16 = 5'd17, ST_M17 = 5'd18, ST_C0  = 5'd19,
                           ST_C1   = 5'd20, ST_C2  = 5'd21, ST_C3  = 5'd22, ST_C4  = 5'd23,
                           ST_C5   = 5'd24, ST_C6  = 5'd25, ST_C7  = 5'd26, ST_OUT = 5'd27;

    logic [4:0]         r_state;
    logic [22:0]        r_thresh;
    logic [19:0]        r_makeup;
    logic [24:0]        r_rate;
    logic [16:0]        r_wet;
    logic [24:0]        r_phase;
    logic [27:0]        r_acc, r_pa, r_pb, r_pc;
    logic signed [26:0] r_last;
    logic               r_pos, r_neg;
    t_sample            r_x;
    logic signed [27:0] r_y;
    logic signed [55:0] r_p, r_s;
    logic [28:0]        r_cbl, r_bal, r_cbal;
    logic [24:0]        r_g;
    logic               r_m_valid;
    t_sample            r_m_data;

    logic signed [29:0] w_ma;
    logic signed [25:0] w_mb;
    logic signed [55:0] w_prod;
    logic [24:0]        w_rate, w_q;
    logic [25:0]        w_phase_sum;
    logic [28:0]        w_acc_sum;
    logic [23:0]        w_mag;
    logic signed [56:0] w_sum;
    logic signed [55:0] w_p24, w_p16;
    logic signed [40:0] w_mix;
    logic [55:0]        w_red;
    logic [56:0]        w_g_full;
    logic signed [27:0] w_last_x;
    logic               w_y_lt_last, w_y_gt_last;
    logic [29:0]        w_cbal_sum;
    logic [16:0]        w_dry_w;

    assign w_rate      = (r_rate > ONE_PHASE) ? ONE_PHASE : r_rate;
    assign w_q         = ONE_PHASE - r_phase;
    assign w_phase_sum = {1'b0, r_phase} + {1'b0, w_rate};
    assign w_mag       = r_x[SAMPLE_W-1] ? 24'(-r_x) : 24'(r_x);
    assign w_acc_sum   = {1'b0, r_acc} + {5'd0, r_p[47:24]};
    assign w_sum       = {r_s[55], r_s} + {r_p[55], r_p};
    assign w_p24       = r_p >>> 24;
    assign w_p16       = r_p >>> 16;
    assign w_mix       = 41'(w_sum >>> 16);
    assign w_red       = (r_p > signed'(RED_LIM)) ? RED_LIM : r_p;
    assign w_g_full    = {1'b0, RED_LIM - w_red} >> 15;
    assign w_last_x    = {r_last[26], r_last};
    assign w_y_lt_last = r_y < w_last_x;
    assign w_y_gt_last = r_y > w_last_x;
    assign w_cbal_sum  = {2'b0, r_pb} + {1'b0, w_sum[52:24]};
    assign w_dry_w     = WET_ONE - r_wet;

    // operand select for the shared multiplier
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            ST_M0:  begin w_ma = 30'({6'd0, w_mag});      w_mb = 26'({1'b0, w_rate}); end
            ST_M2:  begin w_ma = 30'({2'd0, r_pc});       w_mb = 26'({1'b0, w_q});    end
            ST_M3:  begin w_ma = 30'({2'd0, r_pb});       w_mb = 26'({1'b0, r_phase}); end
            ST_M4:  begin w_ma = 30'({2'd0, r_pb});       w_mb = 26'({1'b0, w_q});    end
            ST_M5:  begin w_ma = 30'({2'd0, r_pa});       w_mb = 26'({1'b0, r_phase}); end
            ST_M6:  begin w_ma = 30'({1'b0, r_cbl});      w_mb = 26'({1'b0, w_q});    end
            ST_M7:  begin w_ma = 30'({1'b0, r_bal});      w_mb = 26'({1'b0, r_phase}); end
            ST_M9:  begin w_ma = 30'({1'b0, r_cbal});     w_mb = 26'({3'd0, r_thresh}); end
            ST_M11: begin w_ma = 30'(r_x);                w_mb = 26'({1'b0, r_g});    end
            ST_M13: begin w_ma = 30'(r_y);                w_mb = 26'({6'd0, r_makeup}); end
            ST_M15: begin w_ma = 30'(r_y);                w_mb = 26'({9'd0, r_wet});  end
            ST_M16: begin w_ma = 30'(r_x);                w_mb = 26'({9'd0, w_dry_w}); end
            ST_C0:  begin
                if (w_y_lt_last) begin
                    w_ma = 30'(r_y);
                    w_mb = CLIP_MUL_B;
                end else begin
                    w_ma = 30'(r_last);
                    w_mb = CLIP_MUL_D;
                end
            end
            ST_C4:  begin
                if (w_y_gt_last) begin
                    w_ma = 30'(r_y);
                    w_mb = CLIP_MUL_B;
                end else begin
                    w_ma = 30'(r_last);
                    w_mb = CLIP_MUL_D;
                end
            end
            ST_C2, ST_C6: begin w_ma = 30'(r_last); w_mb = CLIP_MUL_B; end
            default: begin w_ma = '0; w_mb = '0; end
        endcase
    end

    assign w_prod = 56'(w_ma) * 56'(w_mb);

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;

    always_ff @(posedge i_clk) begin
        r_p <= w_prod;
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_thresh  <= '0;
            r_makeup  <= 20'd65536;
            r_rate    <= 25'd1677;
            r_wet     <= WET_ONE;
            r_phase   <= ONE_PHASE;
            r_acc     <= '0;
            r_pa      <= '0;
            r_pb      <= '0;
            r_pc      <= '0;
            r_last    <= '0;
            r_pos     <= 1'b0;
            r_neg     <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_THRESHOLD: r_thresh <= i_cfg_data[22:0];
                    REG_MAKEUP:    r_makeup <= i_cfg_data[19:0];
                    REG_RATE:      r_rate   <= i_cfg_data;
                    REG_WET:       r_wet    <= i_cfg_data[16:0];
                    default: ;
                endcase
            end
            if ((r_state == ST_OUT) && (!r_m_valid || i_m_axis_tready)) begin
                r_m_valid <= 1'b1;
            end else if (r_m_valid && i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_x     <= i_s_axis_tdata;
                        r_state <= ST_M0;
                    end
                end
                ST_M1: begin
                    if (w_phase_sum > {1'b0, ONE_PHASE}) begin
                        r_phase <= 25'(w_phase_sum - {1'b0, ONE_PHASE});
                        r_pc    <= r_pb;
                        r_pb    <= r_pa;
                        r_pa    <= w_acc_sum[28] ? ACC_MAX : w_acc_sum[27:0];
                        r_acc   <= '0;
                    end else begin
                        r_phase <= w_phase_sum[24:0];
                        r_acc   <= w_acc_sum[28] ? ACC_MAX : w_acc_sum[27:0];
                    end
                    r_state <= ST_M2;
                end
                ST_M3, ST_M5, ST_M7, ST_M16: begin
                    r_s     <= r_p;
                    r_state <= r_state + 5'd1;
                end
                ST_M4: begin
                    r_cbl   <= w_sum[52:24];
                    r_state <= ST_M5;
                end
                ST_M6: begin
                    r_bal   <= w_sum[52:24];
                    r_state <= ST_M7;
                end
                ST_M8: begin
                    r_cbal  <= w_cbal_sum[29:1];
                    r_state <= ST_M9;
                end
                ST_M10: begin
                    r_g     <= w_g_full[24:0];
                    r_state <= ST_M11;
                end
                ST_M12: begin
                    r_y     <= w_p24[27:0];
                    r_state <= ST_M13;
                end
                ST_M14: begin
                    r_y     <= w_p16[27:0];
                    r_state <= ST_M15;
                end
                ST_M17: begin
                    if (r_wet < WET_ONE) begin
                        if (w_mix > 41'(CLAMP4)) begin
                            r_y <= CLAMP4;
                        end else if (w_mix < -41'(CLAMP4)) begin
                            r_y <= -CLAMP4;
                        end else begin
                            r_y <= w_mix[27:0];
                        end
                    end else begin
                        if (r_y > CLAMP4) begin
                            r_y <= CLAMP4;
                        end else if (r_y < -CLAMP4) begin
                            r_y <= -CLAMP4;
                        end
                    end
                    r_state <= ST_C0;
                end
                ST_C1: begin
                    if (r_pos) begin
                        r_last <= (w_y_lt_last ? CLIP_OFS_A : CLIP_OFS_C) + w_p24[26:0];
                    end
                    r_state <= ST_C2;
                end
                ST_C3: begin
                    r_pos <= r_y > CLIP_THRESH;
                    if (r_y > CLIP_THRESH) begin
                        r_y <= 28'(CLIP_OFS_A + signed'(w_p24[26:0]));
                    end
                    r_state <= ST_C4;
                end
                ST_C5: begin
                    if (r_neg) begin
                        r_last <= (w_y_gt_last ? -CLIP_OFS_A : -CLIP_OFS_C) + w_p24[26:0];
                    end
                    r_state <= ST_C6;
                end
                ST_C7: begin
                    r_neg <= r_y < -CLIP_THRESH;
                    if (r_y < -CLIP_THRESH) begin
                        r_y <= 28'(-CLIP_OFS_A + signed'(w_p24[26:0]));
                    end
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    // hold until the output register is free
                    if (!r_m_valid || i_m_axis_tready) begin
                        if (r_last > 27'sd8388607) begin
                            r_m_data <= 24'sh7FFFFF;
                        end else if (r_last < -27'sd8388608) begin
                            r_m_data <= 24'sh800000;
                        end else begin
                            r_m_data <= r_last[23:0];
                        end
                        r_last    <= r_y[26:0];
                        r_state   <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= r_state + 5'd1;
                end
            endcase
        end
    end

    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != 25'd0) && (r_phase <= ONE_PHASE))
        else $error("envelope phase out of range");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> (r_state == ST_M0))
        else $error("accepted sample did not start the sequence");

    a_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_C0) |-> ((r_y <= CLAMP4) && (r_y >= -CLAMP4)))
        else $error("clipper input exceeds clamp");

endmodule
`default_nettype wire
